// ===== rtl/arp_icmp_echo_responder_assert.svh =====
// assertion macros for the responder checker
`ifndef ARP_ICMP_ECHO_RESPONDER_ASSERT_SVH
`define ARP_ICMP_ECHO_RESPONDER_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define AIER_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every rising clock edge, reset included
`define AIER_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/aier_pkg.sv =====
package aier_pkg;

    localparam int HDR_LEN   = 42;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP  = 2'd1;

    typedef enum logic [3:0] {
        S_RECV   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    // where a reply word comes from
    typedef enum logic [2:0] {
        K_MEM,
        K_CONST,
        K_MAC,
        K_IPCK,
        K_ICCK
    } t_kind;

    typedef struct packed {
        logic        arp_ok;
        logic        icmp_ok;
        logic        bcast;
        logic [15:0] ip_ck;
        logic [15:0] icmp_ck;
    } t_scan_res;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_rd_req;

endpackage

// ===== rtl/aier_ram.sv =====
module aier_ram (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [aier_pkg::IDX_W-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  aier_pkg::t_rd_req        i_rd,
    output logic [7:0]               o_rdata
);
    import aier_pkg::*;

    logic [7:0] r_mem [HDR_LEN];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/aier_scan.sv =====
module aier_scan (
    input  logic                       i_clk,
    input  logic                       i_start,
    input  logic                       i_valid,
    input  logic [aier_pkg::IDX_W-1:0] i_idx,
    input  logic [7:0]                 i_data,
    input  logic [31:0]                i_local_ip,
    output aier_pkg::t_scan_res        o_res
);
    import aier_pkg::*;

    // header words with a fixed value in the echo reply ip header
    localparam logic [15:0] IP_CONST_SUM = 16'h851d;

    logic        r_t08, r_arp, r_ip, r_f20, r_f21, r_f23, r_f34, r_bcast, r_tip;
    logic [15:0] r_ipsum, r_icsum;
    logic [15:0] word;
    logic [16:0] ip_add, ic_add;
    logic [7:0]  ip_byte;

    assign word   = i_idx[0] ? {8'h00, i_data} : {i_data, 8'h00};
    assign ip_add = {1'b0, r_ipsum} + {1'b0, word};
    assign ic_add = {1'b0, r_icsum} + {1'b0, word};

    always_comb begin
        unique case (i_idx[1:0])
            2'd2:    ip_byte = i_local_ip[31:24];
            2'd3:    ip_byte = i_local_ip[23:16];
            2'd0:    ip_byte = i_local_ip[15:8];
            default: ip_byte = i_local_ip[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bcast <= 1'b1;
            r_tip   <= 1'b1;
            r_ipsum <= IP_CONST_SUM;
            r_icsum <= 16'h0000;
        end else if (i_valid) begin
            if (i_idx == IDX_W'(12)) r_t08 <= (i_data == 8'h08);
            if (i_idx == IDX_W'(13)) begin
                r_arp <= (i_data == 8'h06);
                r_ip  <= (i_data == 8'h00);
            end
            if (i_idx == IDX_W'(20)) r_f20 <= (i_data == 8'h00);
            if (i_idx == IDX_W'(21)) r_f21 <= (i_data == 8'h01);
            if (i_idx == IDX_W'(23)) r_f23 <= (i_data == 8'h01);
            if (i_idx == IDX_W'(34)) r_f34 <= (i_data == 8'h08);
            // sender mac all ones
            if (i_idx >= IDX_W'(22) && i_idx <= IDX_W'(27)) begin
                r_bcast <= r_bcast & (i_data == 8'hff);
            end
            // ip addresses, end-around carry
            if (i_idx >= IDX_W'(26) && i_idx <= IDX_W'(33)) begin
                r_ipsum <= ip_add[15:0] + {15'd0, ip_add[16]};
            end
            // arp target ip, icmp identifier and sequence
            if (i_idx >= IDX_W'(38) && i_idx <= IDX_W'(41)) begin
                r_tip   <= r_tip & (i_data == ip_byte);
                r_icsum <= ic_add[15:0] + {15'd0, ic_add[16]};
            end
        end
    end

    assign o_res.arp_ok  = r_t08 & r_arp & r_f20 & r_f21 & r_tip;
    assign o_res.icmp_ok = r_t08 & r_ip & r_f23 & r_f34;
    assign o_res.bcast   = r_bcast;
    assign o_res.ip_ck   = ~r_ipsum;
    assign o_res.icmp_ck = ~r_icsum;

endmodule

// ===== rtl/aier_emit.sv =====
module aier_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_arp,
    input  aier_pkg::t_scan_res i_res,
    input  logic [47:0]         i_local_mac,
    output aier_pkg::t_rd_req   o_rd,
    input  logic [7:0]          i_rd_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_byte,
    output logic                o_last,
    output logic                o_done
);
    import aier_pkg::*;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] addr;
        logic [7:0]       cbyte;
        logic [2:0]       sel;
    } t_src;

    function automatic logic [7:0] arp_const(input logic [IDX_W-1:0] o);
        logic [7:0] b;
        unique case (o)
            IDX_W'(12): b = 8'h08;
            IDX_W'(13): b = 8'h06;
            IDX_W'(15): b = 8'h01;
            IDX_W'(16): b = 8'h08;
            IDX_W'(18): b = 8'h06;
            IDX_W'(19): b = 8'h04;
            IDX_W'(21): b = 8'h02;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] icmp_const(input logic [IDX_W-1:0] o);
        logic [7:0] b;
        unique case (o)
            IDX_W'(12): b = 8'h08;
            IDX_W'(14): b = 8'h45;
            IDX_W'(17): b = 8'h1c;
            IDX_W'(22): b = 8'h40;
            IDX_W'(23): b = 8'h01;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic t_src src_of(input logic [IDX_W-1:0] o, input logic arp,
                                    input logic bcast);
        t_src s;
        s.kind  = K_MEM;
        s.addr  = o;
        s.cbyte = 8'h00;
        s.sel   = 3'd0;
        if (arp) begin
            priority if (o < IDX_W'(6)) begin
                s.kind = bcast ? K_CONST : K_MEM;
                s.addr = o + IDX_W'(22);
            end else if (o < IDX_W'(12)) begin
                s.kind = K_MAC;
                s.sel  = 3'(o - IDX_W'(6));
            end else if (o < IDX_W'(22)) begin
                s.kind  = K_CONST;
                s.cbyte = arp_const(o);
            end else if (o < IDX_W'(28)) begin
                s.kind = K_MAC;
                s.sel  = 3'(o - IDX_W'(22));
            end else if (o < IDX_W'(32)) begin
                s.addr = o + IDX_W'(10);
            end else begin
                s.addr = o - IDX_W'(10);
            end
        end else begin
            priority if (o < IDX_W'(6)) begin
                s.addr = o + IDX_W'(6);
            end else if (o < IDX_W'(12)) begin
                s.kind = K_MAC;
                s.sel  = 3'(o - IDX_W'(6));
            end else if (o < IDX_W'(24)) begin
                s.kind  = K_CONST;
                s.cbyte = icmp_const(o);
            end else if (o < IDX_W'(26)) begin
                s.kind = K_IPCK;
                s.sel  = {2'b00, o[0]};
            end else if (o < IDX_W'(30)) begin
                s.addr = o + IDX_W'(4);
            end else if (o < IDX_W'(34)) begin
                s.addr = o - IDX_W'(4);
            end else if (o < IDX_W'(36)) begin
                s.kind = K_CONST;
            end else if (o < IDX_W'(38)) begin
                s.kind = K_ICCK;
                s.sel  = {2'b00, o[0]};
            end else begin
                s.addr = o;
            end
        end
        return s;
    endfunction

    logic             r_act, r_arp;
    logic [IDX_W-1:0] r_idx;
    logic             r_pv, r_plast;
    t_src             r_p;
    logic             r_ov, r_olast;
    logic [7:0]       r_obyte;
    logic             adv, issue;
    t_src             cur;
    logic [7:0]       mac_b, fmt;

    assign adv   = !r_ov || i_ready;
    assign issue = r_act && adv;
    assign cur   = src_of(r_idx, r_arp, i_res.bcast);

    assign o_rd.en   = issue && (cur.kind == K_MEM);
    assign o_rd.addr = cur.addr;

    always_comb begin
        unique case (r_p.sel)
            3'd0:    mac_b = i_local_mac[47:40];
            3'd1:    mac_b = i_local_mac[39:32];
            3'd2:    mac_b = i_local_mac[31:24];
            3'd3:    mac_b = i_local_mac[23:16];
            3'd4:    mac_b = i_local_mac[15:8];
            default: mac_b = i_local_mac[7:0];
        endcase
    end

    always_comb begin
        unique case (r_p.kind)
            K_MEM:   fmt = i_rd_data;
            K_MAC:   fmt = mac_b;
            K_IPCK:  fmt = r_p.sel[0] ? i_res.ip_ck[7:0] : i_res.ip_ck[15:8];
            K_ICCK:  fmt = r_p.sel[0] ? i_res.icmp_ck[7:0] : i_res.icmp_ck[15:8];
            default: fmt = r_p.cbyte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_start) begin
                r_act <= 1'b1;
            end else if (issue && r_idx == IDX_W'(HDR_LEN - 1)) begin
                r_act <= 1'b0;
            end
            if (adv) begin
                r_pv <= issue;
                r_ov <= r_pv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx <= '0;
            r_arp <= i_arp;
        end else if (issue) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (issue) begin
            r_p     <= cur;
            r_plast <= (r_idx == IDX_W'(HDR_LEN - 1));
        end
        if (adv) begin
            r_obyte <= fmt;
            r_olast <= r_plast;
        end
    end

    assign o_valid = r_ov;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;
    assign o_done  = r_ov && i_ready && r_olast;

endmodule

// ===== rtl/arp_icmp_echo_responder.sv =====
// ARP and ICMP echo responder. Received Ethernet frames come in one byte per
// word on the s_axis side, tlast on the final byte; the first 42 bytes of
// each frame go into a 42-entry header memory and the rest is dropped. When
// a frame of at least 42 bytes ends, the block reads the header back out of
// the memory (one byte a cycle), checks it and folds the two checksums, then
// makes its decision. An ARP request for local_ip gets an ARP reply; an IPv4
// ICMP echo request gets a header-only echo reply with swapped addresses and
// fresh checksums. The 42-byte reply goes out on m_axis at one byte per cycle
// when the sink keeps tready high, tlast on the final byte; the bytes it copies
// are read from the same memory through its single read port. s_axis_tready is
// high only while receiving: it drops after the last byte of a full-length
// frame and comes back after the scan and the decision when no reply is made,
// or after the last reply byte is taken. Shorter frames cost nothing, so frames
// stream in at one byte per cycle. local_mac and local_ip are written through
// the cfg port, index 0 and 1; the user must write them only while the block
// is idle, as the block itself does not enforce it.
module arp_icmp_echo_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // frame in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  logic        s_axis_tlast,   // frame_end
    // reply out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] reply_byte
    output logic        m_axis_tlast,   // reply_end
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [aier_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import aier_pkg::*;

    t_state           r_state, n_state;
    logic [47:0]      r_local_mac;
    logic [31:0]      r_local_ip;
    logic [IDX_W-1:0] r_cnt;        // header bytes stored so far
    logic [IDX_W-1:0] r_scan_idx;   // next header byte to read back
    logic             r_rd_v;       // read data valid for the scanner
    logic [IDX_W-1:0] r_rd_idx;
    logic             in_acc, room, frame_full, scan_start;
    logic             scan_issue, emit_start, emit_done;
    t_rd_req          scan_rd, emit_rd, ram_rd;
    logic [7:0]       rd_data;
    t_scan_res        res;

    // register writes, always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_mac <= '0;
            r_local_ip  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOCAL_MAC: r_local_mac <= i_cfg_data;
                CFG_LOCAL_IP:  r_local_ip  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // receive side
    assign s_axis_tready = (r_state == S_RECV);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign room          = (r_cnt != IDX_W'(HDR_LEN));
    // full once the 42nd byte is in, this word included
    assign frame_full    = !room || (r_cnt == IDX_W'(HDR_LEN - 1));
    assign scan_start    = in_acc && s_axis_tlast && frame_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc) begin
            if (s_axis_tlast) begin
                r_cnt <= '0;
            end else if (room) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end
        end
    end

    // header read-back for the checks
    assign scan_issue   = (r_state == S_SCAN) && (r_scan_idx != IDX_W'(HDR_LEN));
    assign scan_rd.en   = scan_issue;
    assign scan_rd.addr = r_scan_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= scan_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_start) begin
            r_scan_idx <= '0;
        end else if (scan_issue) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
        r_rd_idx <= r_scan_idx;
    end

    // one read port, shared: scan and emit never overlap
    assign ram_rd = emit_rd.en ? emit_rd : scan_rd;

    // control
    assign emit_start = (r_state == S_DECIDE) && (res.arp_ok || res.icmp_ok);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RECV:   if (scan_start) n_state = S_SCAN;
            S_SCAN:   if (r_rd_v && r_rd_idx == IDX_W'(HDR_LEN - 1)) n_state = S_DECIDE;
            S_DECIDE: n_state = emit_start ? S_EMIT : S_RECV;
            S_EMIT:   if (emit_done) n_state = S_RECV;
            default:  n_state = S_RECV;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    aier_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && room),
        .i_waddr (r_cnt),
        .i_wdata (s_axis_tdata),
        .i_rd    (ram_rd),
        .o_rdata (rd_data)
    );

    aier_scan u_scan (
        .i_clk      (i_clk),
        .i_start    (scan_start),
        .i_valid    (r_rd_v),
        .i_idx      (r_rd_idx),
        .i_data     (rd_data),
        .i_local_ip (r_local_ip),
        .o_res      (res)
    );

    aier_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (emit_start),
        .i_arp       (res.arp_ok),
        .i_res       (res),
        .i_local_mac (r_local_mac),
        .o_rd        (emit_rd),
        .i_rd_data   (rd_data),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_done      (emit_done)
    );

endmodule

// ===== rtl/aier_checker.sv =====
`include "arp_icmp_echo_responder_assert.svh"

module aier_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [aier_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [47:0] i_cfg_data
);
    // the receive side is held off while a reply is out
    `AIER_CHECK(a_no_rx_during_tx, m_axis_tvalid |-> !s_axis_tready, "input ready during reply")

    // a stalled reply word holds
    `AIER_CHECK(a_tx_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled reply word changed")

    // nothing follows the last reply byte directly
    `AIER_CHECK(a_gap_after_reply, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid, "reply continues past its end")

    // the header scan lies between a frame end and its reply
    `AIER_CHECK(a_scan_before_reply, s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !m_axis_tvalid, "reply right after frame end")

endmodule

bind arp_icmp_echo_responder aier_checker u_aier_checker (.*);

// ===== dv/tb_arp_icmp_echo_responder.sv =====
`timescale 1ns / 1ps

module tb_arp_icmp_echo_responder;
    import aier_pkg::*;

    // run control
    localparam int WATCHDOG_LIMIT   = 4000;  // cycles with no word moving on any port
    localparam int DRAIN_CYCLES     = 60;    // covers the scan of a frame left unanswered
    localparam int HOLD_OFF_CYCLES  = 300;   // long sink stall, lets the block back up its input
    localparam int RANDOM_BYTES_MIN = 45;    // minimum random frame bytes per phase
    localparam int REPLIES_MIN      = 2;     // minimum replies per random phase

    // protocol codes
    localparam logic [15:0] ETH_TYPE_ARP      = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETH_TYPE_IPV6     = 16'h86dd;
    localparam logic [15:0] ARP_HTYPE_ETH     = 16'h0001;
    localparam logic [15:0] ARP_OP_REQUEST    = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY      = 16'h0002;
    localparam logic [7:0]  MAC_ADDR_LEN      = 8'd6;
    localparam logic [7:0]  IP_ADDR_LEN       = 8'd4;
    localparam logic [7:0]  IP_VER_IHL        = 8'h45;
    localparam logic [15:0] IP_TOTAL_LEN      = 16'd28;
    localparam logic [7:0]  IP_TTL            = 8'd64;
    localparam logic [7:0]  IP_PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  IP_PROTO_UDP      = 8'd17;
    localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
    localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;

    // what a generated frame looks like
    typedef enum logic [3:0] {
        FR_ARP_REQ,       // arp request for our address
        FR_ARP_BCAST,     // same, sender mac all ones
        FR_ARP_STRANGER,  // arp request for some other address
        FR_ARP_REPLY,     // arp reply addressed to us
        FR_ICMP_ECHO,     // ipv4 icmp echo request
        FR_ICMP_OTHER,    // ipv4 icmp, not an echo request
        FR_IPV4_OTHER,    // ipv4, not icmp
        FR_OTHER_TYPE,    // some other ethertype
        FR_NOISE          // random bytes throughout
    } frame_kind_t;

    // filler for the bytes a frame kind leaves free
    typedef enum logic [1:0] {
        FILL_RAND,
        FILL_ZERO,
        FILL_ONES
    } fill_t;

    typedef struct packed {
        frame_kind_t kind;
        logic [7:0]  len;
        fill_t       fill;
        logic        no_reply;  // typed in: the frame must draw nothing
    } frame_row_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_word_t;

    // directed frames, run with the reset addresses (mac 0, ip 0.0.0.0)
    localparam frame_row_t DIRECTED [15] = '{
        // kind            len  fill       no reply
        '{FR_ARP_REQ,      42, FILL_RAND, 1'b0},  // request for the reset address
        '{FR_ARP_REQ,      42, FILL_ZERO, 1'b0},
        '{FR_ARP_BCAST,    42, FILL_RAND, 1'b0},  // all-ones sender, zero destination back
        '{FR_ARP_REQ,      64, FILL_ONES, 1'b0},  // long frame, all-ones sender too
        '{FR_ICMP_ECHO,    42, FILL_RAND, 1'b0},
        '{FR_ICMP_ECHO,    42, FILL_ONES, 1'b0},  // checksums with end-around carries
        '{FR_ICMP_ECHO,    42, FILL_ZERO, 1'b0},
        '{FR_ICMP_ECHO,    99, FILL_RAND, 1'b0},  // bytes past the header are dropped
        '{FR_ICMP_ECHO,    41, FILL_RAND, 1'b1},  // one byte short
        '{FR_ARP_REQ,       1, FILL_ONES, 1'b1},  // single-byte frame
        '{FR_ARP_STRANGER, 42, FILL_RAND, 1'b1},
        '{FR_ARP_REPLY,    42, FILL_RAND, 1'b1},  // received replies are ignored
        '{FR_ICMP_OTHER,   42, FILL_RAND, 1'b1},
        '{FR_IPV4_OTHER,   42, FILL_RAND, 1'b1},
        '{FR_OTHER_TYPE,   42, FILL_RAND, 1'b1}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;   // [7:0] frame_byte
    logic                 s_axis_tlast;   // frame_end
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;   // [7:0] reply_byte
    logic                 m_axis_tlast;   // reply_end
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [47:0]          i_cfg_data;

    // responder model state: own addresses and the captured header
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [7:0]  hdr_mem [HDR_LEN];
    int          hdr_cnt;
    logic [7:0]  reply_buf [HDR_LEN];
    reply_word_t reply_q [$];       // reply words still owed by the block

    logic [7:0]  frame_buf [$];     // frame being sent
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_off_req   = 1'b0;
    int          fail_cnt       = 0;
    int          stall_cycles   = 0;

    arp_icmp_echo_responder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // internet checksum over big-endian 16-bit words of reply_buf
    function automatic logic [15:0] ones_cksum(input int first, input int len);
        logic [31:0] acc;
        acc = '0;
        for (int k = 0; k + 1 < len; k += 2)
            acc += {16'h0, reply_buf[first + k], reply_buf[first + k + 1]};
        while (acc[31:16] != 16'h0)
            acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        return ~acc[15:0];
    endfunction

    // feed one accepted frame byte to the model; on a frame end that draws
    // a reply the 42 reply bytes are left in reply_buf
    task automatic predict_reply(input logic [7:0] b, input logic last, output bit made);
        logic [31:0] tgt_ip;
        logic        bcast;
        logic [15:0] ck;
        made = 1'b0;
        if (hdr_cnt < HDR_LEN) begin
            hdr_mem[hdr_cnt] = b;
            hdr_cnt++;
        end
        if (last) begin
            if (hdr_cnt == HDR_LEN) begin
                for (int k = 0; k < HDR_LEN; k++)
                    reply_buf[k] = 8'h00;
                if ({hdr_mem[12], hdr_mem[13]} == ETH_TYPE_ARP) begin
                    tgt_ip = {hdr_mem[38], hdr_mem[39], hdr_mem[40], hdr_mem[41]};
                    // only the opcode and target address are checked
                    if (tgt_ip == own_ip && {hdr_mem[20], hdr_mem[21]} == ARP_OP_REQUEST) begin
                        made  = 1'b1;
                        bcast = 1'b1;
                        for (int k = 0; k < 6; k++)
                            if (hdr_mem[22 + k] != 8'hff)
                                bcast = 1'b0;
                        for (int k = 0; k < 6; k++) begin
                            reply_buf[k]      = bcast ? 8'h00 : hdr_mem[22 + k];
                            reply_buf[6 + k]  = own_mac[47 - 8 * k -: 8];
                            reply_buf[22 + k] = own_mac[47 - 8 * k -: 8];
                            reply_buf[32 + k] = hdr_mem[22 + k];  // sender mac as received
                        end
                        {reply_buf[12], reply_buf[13]} = ETH_TYPE_ARP;
                        {reply_buf[14], reply_buf[15]} = ARP_HTYPE_ETH;
                        {reply_buf[16], reply_buf[17]} = ETH_TYPE_IPV4;
                        reply_buf[18] = MAC_ADDR_LEN;
                        reply_buf[19] = IP_ADDR_LEN;
                        {reply_buf[20], reply_buf[21]} = ARP_OP_REPLY;
                        for (int k = 0; k < 4; k++) begin
                            reply_buf[28 + k] = hdr_mem[38 + k];
                            reply_buf[38 + k] = hdr_mem[28 + k];
                        end
                    end
                end else if ({hdr_mem[12], hdr_mem[13]} == ETH_TYPE_IPV4) begin
                    // icmp header assumed at offset 34 whatever the ihl says
                    if (hdr_mem[23] == IP_PROTO_ICMP && hdr_mem[34] == ICMP_ECHO_REQUEST) begin
                        made = 1'b1;
                        for (int k = 0; k < 6; k++) begin
                            reply_buf[k]     = hdr_mem[6 + k];
                            reply_buf[6 + k] = own_mac[47 - 8 * k -: 8];
                        end
                        {reply_buf[12], reply_buf[13]} = ETH_TYPE_IPV4;
                        reply_buf[14] = IP_VER_IHL;
                        {reply_buf[16], reply_buf[17]} = IP_TOTAL_LEN;
                        reply_buf[22] = IP_TTL;
                        reply_buf[23] = IP_PROTO_ICMP;
                        for (int k = 0; k < 4; k++) begin
                            reply_buf[26 + k] = hdr_mem[30 + k];
                            reply_buf[30 + k] = hdr_mem[26 + k];
                            reply_buf[38 + k] = hdr_mem[38 + k];  // identifier, sequence
                        end
                        ck = ones_cksum(14, 20);
                        {reply_buf[24], reply_buf[25]} = ck;
                        reply_buf[34] = ICMP_ECHO_REPLY;
                        ck = ones_cksum(34, 8);
                        {reply_buf[36], reply_buf[37]} = ck;
                    end
                end
            end
            hdr_cnt = 0;
        end
    endtask

    // write a byte of frame_buf if the frame reaches that far
    function automatic void set_field(input int at, input logic [7:0] v);
        if (at < frame_buf.size())
            frame_buf[at] = v;
    endfunction

    function automatic void build_frame(input frame_kind_t kind, input int len, input fill_t fill);
        int idx;
        frame_buf.delete();
        for (int k = 0; k < len; k++) begin
            case (fill)
                FILL_ZERO: frame_buf.push_back(8'h00);
                FILL_ONES: frame_buf.push_back(8'hff);
                default:   frame_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        case (kind)
            FR_ARP_REQ, FR_ARP_BCAST, FR_ARP_STRANGER, FR_ARP_REPLY: begin
                set_field(12, ETH_TYPE_ARP[15:8]);
                set_field(13, ETH_TYPE_ARP[7:0]);
                set_field(20, 8'h00);
                set_field(21, kind == FR_ARP_REPLY ? ARP_OP_REPLY[7:0] : ARP_OP_REQUEST[7:0]);
                for (int k = 0; k < 4; k++)
                    set_field(38 + k, own_ip[31 - 8 * k -: 8]);
                if (kind == FR_ARP_BCAST)
                    for (int k = 0; k < 6; k++)
                        set_field(22 + k, 8'hff);
                if (kind == FR_ARP_STRANGER) begin
                    // spoil one byte of the target address
                    idx = $urandom_range(0, 3);
                    set_field(38 + idx, own_ip[31 - 8 * idx -: 8] ^ 8'($urandom_range(1, 255)));
                end
            end
            FR_ICMP_ECHO, FR_ICMP_OTHER, FR_IPV4_OTHER: begin
                set_field(12, ETH_TYPE_IPV4[15:8]);
                set_field(13, ETH_TYPE_IPV4[7:0]);
                set_field(23, kind == FR_IPV4_OTHER ? IP_PROTO_UDP : IP_PROTO_ICMP);
                set_field(34, kind == FR_ICMP_OTHER ? ICMP_ECHO_REPLY : ICMP_ECHO_REQUEST);
            end
            FR_OTHER_TYPE: begin
                set_field(12, ETH_TYPE_IPV6[15:8]);
                set_field(13, ETH_TYPE_IPV6[7:0]);
            end
            default: ;
        endcase
    endfunction

    // send frame_buf word by word with random sender gaps; queue the reply
    // the model predicts unless the row has no reply typed in
    task automatic send_frame(input bit no_reply, output bit replied);
        bit made;
        bit is_last;
        replied = 1'b0;
        for (int k = 0; k < frame_buf.size(); k++) begin
            while ($urandom_range(0, 99) < send_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            is_last = (k == frame_buf.size() - 1);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= frame_buf[k];
            s_axis_tlast  <= is_last;
            do @(posedge i_clk); while (!s_axis_tready);
            predict_reply(frame_buf[k], is_last, made);
            if (made && !no_reply) begin
                for (int j = 0; j < HDR_LEN; j++)
                    reply_q.push_back(reply_word_t'{reply_buf[j], j == HDR_LEN - 1});
                replied = 1'b1;
            end
        end
    endtask

    // wait out every owed reply word, then the scan of an unanswered frame
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // both registers in one burst; valid stays up between the two words
    task automatic load_config(input logic [47:0] mac, input logic [31:0] ip);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_LOCAL_MAC;
        i_cfg_data  <= mac;
        do @(posedge i_clk); while (!o_cfg_ready);
        own_mac = mac;
        i_cfg_index <= CFG_LOCAL_IP;
        i_cfg_data  <= {16'($urandom), ip};  // upper bits are don't-care
        do @(posedge i_clk); while (!o_cfg_ready);
        own_ip = ip;
        i_cfg_valid <= 1'b0;
    endtask

    // reply sink: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // reply checker: every word against the oldest owed word
    always @(posedge i_clk) begin
        reply_word_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reply_q.size() == 0) begin
                $error("unexpected reply word: reply_byte %h reply_end %b",
                       m_axis_tdata, m_axis_tlast);
                fail_cnt++;
            end else begin
                want = reply_q.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $error("reply_byte mismatch: expected %h, actual %h", want.data, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("reply_end mismatch: expected %b, actual %b", want.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: cycles in which no word moves on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("tb_arp_icmp_echo_responder failed");
        $finish;
    end

    initial begin
        frame_kind_t kind;
        int          len;
        int          pick;
        bit          replied;
        int          phase_bytes;
        int          phase_replies;
        logic [47:0] mac;
        logic [31:0] ip;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_LOCAL_MAC;
        i_cfg_data    = '0;
        own_mac       = '0;
        own_ip        = '0;
        hdr_cnt       = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames, no idling, reset addresses
        foreach (DIRECTED[r]) begin
            build_frame(DIRECTED[r].kind, DIRECTED[r].len, DIRECTED[r].fill);
            send_frame(DIRECTED[r].no_reply, replied);
        end

        // random phases, each with its own addresses and idling
        for (int ph = 0; ph < 4; ph++) begin
            drain_replies();
            case (ph)
                0: begin  // no idling, all-ones addresses
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    mac = '1;
                    ip  = '1;
                end
                1: begin  // sender idles
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                    mac = {16'($urandom), 32'($urandom)};
                    ip  = $urandom;
                end
                2: begin  // sink stalls, zero mac
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                    mac = '0;
                    ip  = $urandom;
                end
                default: begin  // both, zero ip
                    send_idle_pct  = 38;
                    recv_stall_pct = 38;
                    mac = {16'($urandom), 32'($urandom)};
                    ip  = '0;
                end
            endcase
            load_config(mac, ip);
            // long sink hold-off while frames keep coming
            if (ph == 2)
                hold_off_req = 1'b1;

            phase_bytes   = 0;
            phase_replies = 0;
            while (phase_bytes < RANDOM_BYTES_MIN || phase_replies < REPLIES_MIN) begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                    kind = FR_ICMP_ECHO;
                else if (pick < 55)
                    kind = FR_ARP_REQ;
                else if (pick < 60)
                    kind = FR_ARP_BCAST;
                else if (pick < 66)
                    kind = FR_ARP_STRANGER;
                else if (pick < 72)
                    kind = FR_ARP_REPLY;
                else if (pick < 78)
                    kind = FR_ICMP_OTHER;
                else if (pick < 84)
                    kind = FR_IPV4_OTHER;
                else if (pick < 90)
                    kind = FR_OTHER_TYPE;
                else
                    kind = FR_NOISE;
                // mostly header-sized frames, some short, some long
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    len = $urandom_range(1, HDR_LEN - 1);
                else if (pick < 65)
                    len = HDR_LEN;
                else if (pick < 95)
                    len = $urandom_range(HDR_LEN + 1, 64);
                else
                    len = $urandom_range(65, 120);
                build_frame(kind, len, FILL_RAND);
                send_frame(1'b0, replied);
                phase_bytes   += len;
                phase_replies += replied;
            end
        end

        drain_replies();
        if (fail_cnt == 0)
            $display("tb_arp_icmp_echo_responder passed");
        else
            $display("tb_arp_icmp_echo_responder failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/aier_pkg.sv
rtl/aier_ram.sv
rtl/aier_scan.sv
rtl/aier_emit.sv
rtl/arp_icmp_echo_responder.sv
rtl/aier_checker.sv
dv/tb_arp_icmp_echo_responder.sv
